/* rtl/mcog_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle octant generator package
// Shared constants, request and status codes and the octant point table.
// ----------------------------------------------------------------------------
package mcog_pkg;

   // Default field widths
   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_BITS_DEF  = 12;

   // Depth of the job queue between step logic and point emitter
   localparam int JOB_QUEUE_DEPTH = 4;

   // Eight symmetric points per step
   localparam int POINTS_PER_STEP = 8;
   localparam int PT_IDX_BITS     = 3;

   // Request kinds (req_tuser)
   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // Result status (rsp_tuser[1])
   localparam logic STATUS_POINT = 1'b0;
   localparam logic STATUS_IDLE  = 1'b1;

   // How one octant point is formed from (x, y):
   // swap selects (y, x) instead of (x, y); neg_a/neg_b subtract the term
   typedef struct packed {
      logic swap;
      logic neg_a;
      logic neg_b;
   } point_sel_type;

   function automatic point_sel_type point_sel(input logic [PT_IDX_BITS-1:0] idx);
      point_sel_type sel;
      begin
         case (idx)
            3'd0:    sel = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b1};
            3'd1:    sel = '{swap: 1'b0, neg_a: 1'b1, neg_b: 1'b0};
            3'd2:    sel = '{swap: 1'b0, neg_a: 1'b1, neg_b: 1'b1};
            3'd3:    sel = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b0};
            3'd4:    sel = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b1};
            3'd5:    sel = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b0};
            3'd6:    sel = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b1};
            3'd7:    sel = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b0};
            default: sel = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b0};
         endcase
         return sel;
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/mcog_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle step front end
// Accepts request items, keeps the circle state, runs one midpoint step per
// active advance and pushes a job {idle, done, y, x, cy, cx} to the queue.
// ----------------------------------------------------------------------------
module mcog_front
   import mcog_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int REQ_DATA_W = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
   localparam int JOB_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       job_valid,
   input  wire logic                  job_ready,
   output logic [JOB_W-1:0]           job_data
);

   localparam int DEC_BITS = RADIUS_BITS + 4;

   // Circle state
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;
   logic [RADIUS_BITS-1:0]       x_ff, x_in;
   logic [RADIUS_BITS-1:0]       y_ff, y_in;
   logic signed [DEC_BITS-1:0]   dec_ff, dec_in;
   logic                         active_ff, active_in;

   // Request fields
   logic [COORD_BITS-1:0]  f_cx;
   logic [COORD_BITS-1:0]  f_cy;
   logic [RADIUS_BITS-1:0] f_rad;
   logic                   accept;

   // Step datapath
   logic [RADIUS_BITS:0]   x_inc;
   logic [DEC_BITS-1:0]    x_inc_ext;
   logic [DEC_BITS-1:0]    y_dec;
   logic [DEC_BITS-1:0]    dec_east;
   logic [DEC_BITS-1:0]    dec_diag;
   logic [RADIUS_BITS-1:0] x_step;
   logic [RADIUS_BITS-1:0] y_step;
   logic                   step_done;
   logic                   job_done;
   logic                   job_idle;

   assign f_cx  = req_tdata[COORD_BITS-1:0];
   assign f_cy  = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign f_rad = req_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

   // Every item becomes exactly one job
   assign req_tready = job_ready;
   assign job_valid  = req_tvalid;
   assign accept     = req_tvalid && job_ready;

   // One midpoint step
   always_comb begin
      x_inc     = {1'b0, x_ff} + 1'b1;
      x_inc_ext = {{(DEC_BITS - RADIUS_BITS - 1){1'b0}}, x_inc};
      y_dec     = {{(DEC_BITS - RADIUS_BITS){1'b0}}, y_ff} - 1'b1;
      dec_east  = dec_ff + {x_inc_ext[DEC_BITS-2:0], 1'b1};
      dec_diag  = dec_east - {y_dec[DEC_BITS-2:0], 1'b0};
      x_step    = x_inc[RADIUS_BITS-1:0];
      y_step    = dec_ff[DEC_BITS-1] ? y_ff : y_dec[RADIUS_BITS-1:0];
      step_done = (x_step >= y_step);
   end

   // Next state and job contents
   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      active_in = active_ff;
      job_done  = 1'b0;
      job_idle  = 1'b0;
      case (req_tuser)
         REQ_START: begin
            cx_in     = f_cx;
            cy_in     = f_cy;
            x_in      = '0;
            y_in      = f_rad;
            dec_in    = DEC_BITS'(1) - {{(DEC_BITS - RADIUS_BITS){1'b0}}, f_rad};
            active_in = (f_rad != '0);
            job_done  = (f_rad == '0);
         end
         REQ_ADVANCE: begin
            if (active_ff) begin
               x_in      = x_step;
               y_in      = y_step;
               dec_in    = dec_ff[DEC_BITS-1] ? dec_east : dec_diag;
               active_in = !step_done;
               job_done  = step_done;
            end else begin
               job_idle  = 1'b1;
            end
         end
         default: begin
            job_idle = 1'b1;
         end
      endcase
   end

   assign job_data = {job_idle, job_done, y_in, x_in, cy_in, cx_in};

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         dec_ff    <= '0;
         active_ff <= 1'b0;
      end else if (accept) begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         dec_ff    <= dec_in;
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/mcog_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Small synchronous FIFO that decouples the step logic from the emitter.
// ----------------------------------------------------------------------------
module mcog_queue
   import mcog_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = JOB_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/mcog_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Octant point emitter
// Takes one job from the queue and emits its eight symmetric points, one per
// cycle unless stalled, or one idle status item, via a registered output stage.
// ----------------------------------------------------------------------------
module mcog_back
   import mcog_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int PT_BITS    = COORD_BITS + 1,
   localparam int RSP_DATA_W = ((2 * PT_BITS + 7) / 8) * 8,
   localparam int JOB_W      = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  wire logic [JOB_W-1:0] job_data,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser
);

   localparam int SUM_W = ((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS) + 2;

   // Job fields
   logic [COORD_BITS-1:0]  j_cx;
   logic [COORD_BITS-1:0]  j_cy;
   logic [RADIUS_BITS-1:0] j_x;
   logic [RADIUS_BITS-1:0] j_y;
   logic                   j_done;
   logic                   j_idle;

   // Point sequencing
   logic [PT_IDX_BITS-1:0] idx_ff, idx_in;
   point_sel_type          sel;
   logic                   load;
   logic                   fire;
   logic                   last_pt;

   // Point arithmetic
   logic [RADIUS_BITS-1:0] term_a;
   logic [RADIUS_BITS-1:0] term_b;
   logic [SUM_W-1:0]       cx_ext;
   logic [SUM_W-1:0]       cy_ext;
   logic [SUM_W-1:0]       a_ext;
   logic [SUM_W-1:0]       b_ext;
   logic [SUM_W-1:0]       sum_x;
   logic [SUM_W-1:0]       sum_y;

   // Output stage
   logic                   valid_ff, valid_in;
   logic [PT_BITS-1:0]     px_ff, px_in;
   logic [PT_BITS-1:0]     py_ff, py_in;
   logic                   last_ff, last_in;
   logic                   done_ff, done_in;
   logic                   status_ff, status_in;

   assign {j_idle, j_done, j_y, j_x, j_cy, j_cx} = job_data;

   // Output register takes a new item when empty or being drained
   assign load      = !valid_ff || rsp_tready;
   assign fire      = load && job_valid;
   assign last_pt   = j_idle || (idx_ff == PT_IDX_BITS'(POINTS_PER_STEP - 1));
   assign job_ready = load && last_pt;

   // Octant point for the current index
   always_comb begin
      sel    = point_sel(idx_ff);
      term_a = sel.swap ? j_y : j_x;
      term_b = sel.swap ? j_x : j_y;
      cx_ext = {{(SUM_W - COORD_BITS){j_cx[COORD_BITS-1]}}, j_cx};
      cy_ext = {{(SUM_W - COORD_BITS){j_cy[COORD_BITS-1]}}, j_cy};
      a_ext  = {{(SUM_W - RADIUS_BITS){1'b0}}, term_a};
      b_ext  = {{(SUM_W - RADIUS_BITS){1'b0}}, term_b};
      sum_x  = sel.neg_a ? (cx_ext - a_ext) : (cx_ext + a_ext);
      sum_y  = sel.neg_b ? (cy_ext - b_ext) : (cy_ext + b_ext);
   end

   // Next index and output stage contents
   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      status_in = status_ff;
      if (load) begin
         valid_in = job_valid;
      end
      if (fire) begin
         idx_in    = last_pt ? '0 : idx_ff + 1'b1;
         last_in   = last_pt;
         if (j_idle) begin
            px_in     = '0;
            py_in     = '0;
            done_in   = 1'b0;
            status_in = STATUS_IDLE;
         end else begin
            px_in     = sum_x[PT_BITS-1:0];
            py_in     = sum_y[PT_BITS-1:0];
            done_in   = j_done;
            status_in = STATUS_POINT;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      last_ff   <= last_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * PT_BITS){1'b0}}, py_ff, px_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {status_ff, done_ff};

endmodule
`default_nettype wire

/* rtl/midpoint_circle_octant_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle octant generator
// Rasterizes a circle by the midpoint method with eight-way symmetry.
//
//   channel | dir | tdata (low bit up)             | tuser               | tlast
//   req     | in  | center_x, center_y, radius     | req_type            | -
//   rsp     | out | point_x, point_y               | arc_done, status    | last_in_run
//
// A start or advance item passes through the step logic combinationally and
// becomes one job in a four-entry queue. The emitter sends eight points per
// job, one per cycle while not stalled, or one idle status item per idle advance.
// Requests are taken every cycle until the queue is full; the output register
// lets the emitter load a new point in the cycle the previous one is taken.
// Reset is synchronous and empties the queue and the output stage.
// ----------------------------------------------------------------------------
module midpoint_circle_octant_generator
   import mcog_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int REQ_DATA_W = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // center_x, center_y, radius
   input  wire logic                  req_tuser,   // req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // point_x, point_y
   output logic                       rsp_tlast,   // last_in_run
   output logic [1:0]                 rsp_tuser    // arc_done, status
);

   localparam int JOB_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 2;

   logic             push_valid;
   logic             push_ready;
   logic [JOB_W-1:0] push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [JOB_W-1:0] pop_data;

   // Step logic
   mcog_front #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (push_valid),
      .job_ready  (push_ready),
      .job_data   (push_data)
   );

   // Job queue
   mcog_queue #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // Point emitter
   mcog_back #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

/* rtl/mcog_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle octant generator port checker
// Watches the request handshake and the result channel of the top level.
// ----------------------------------------------------------------------------
module mcog_checker
   import mcog_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   localparam int RSP_DATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [1:0]            rsp_tuser
);

   // Nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // The input only stalls when the queue is full, so points are on offer
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |-> rsp_tvalid)
      else $error("input stalled with no result on offer");

   // An idle status item is a lone, zeroed item that never ends an arc
   a_idle_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1] == STATUS_IDLE) |->
         (rsp_tlast && rsp_tdata == '0 && !rsp_tuser[0]))
      else $error("malformed idle status item");

   // Within a run of points the arc_done flag does not change
   a_done_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) ##1 rsp_tvalid |->
         (rsp_tuser[0] == $past(rsp_tuser[0]) && rsp_tuser[1] == STATUS_POINT))
      else $error("arc_done or status changed inside a run of points");

   // A stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

endmodule

bind midpoint_circle_octant_generator mcog_checker #(
   .COORD_BITS (COORD_BITS)
) u_mcog_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* verif/circle_point_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point monitor
// Watches the request and point channels of the octant generator. It keeps
// its own copy of the arc state and works out the points that each accepted
// request must produce. Each accepted point is compared field by field
// against the oldest point still owed.
// ----------------------------------------------------------------------------
module circle_point_monitor
   import mcog_pkg::*;
#(
   parameter int REQ_DATA_W = ((2 * COORD_BITS_DEF + RADIUS_BITS_DEF + 7) / 8) * 8,
   parameter int RSP_DATA_W = ((2 * (COORD_BITS_DEF + 1) + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // center_x, center_y, radius
   input  logic                  req_tuser,   // req_type
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // point_x, point_y
   input  logic                  rsp_tlast,   // last_in_run
   input  logic [1:0]            rsp_tuser,   // arc_done, status
   output int                    mismatch_count,
   output int                    open_points
);

   localparam int RADIUS_W = RADIUS_BITS_DEF;
   localparam int COORD_W  = COORD_BITS_DEF;
   localparam int PT_W     = COORD_W + 1;
   localparam int DEC_W    = RADIUS_W + 4;

   // One point (or idle status) as it should appear on the result channel
   typedef struct packed {
      logic signed [PT_W-1:0] px;
      logic signed [PT_W-1:0] py;
      logic                   last;
      logic                   done;
      logic                   status;
   } circle_point_type;

   circle_point_type expected_points[$];
   int               fail_total = 0;

   // Arc state as the generator should hold it
   logic signed [COORD_W-1:0] ctr_x   = '0;
   logic signed [COORD_W-1:0] ctr_y   = '0;
   logic [RADIUS_W-1:0]       pos_x   = '0;
   logic [RADIUS_W-1:0]       pos_y   = '0;
   logic signed [DEC_W-1:0]   dec_val = '0;
   logic                      arc_on  = 1'b0;

   // Queue the eight mirrored points of the current (x, y)
   task automatic push_octants(input logic done);
      int               cx, cy, x, y, ax, ay;
      circle_point_type pt;
      cx = ctr_x;
      cy = ctr_y;
      x  = pos_x;
      y  = pos_y;
      for (int k = 0; k < POINTS_PER_STEP; k++) begin
         case (k)
            0:       begin ax = cx + x; ay = cy - y; end
            1:       begin ax = cx - x; ay = cy + y; end
            2:       begin ax = cx - x; ay = cy - y; end
            3:       begin ax = cx + y; ay = cy + x; end
            4:       begin ax = cx + y; ay = cy - x; end
            5:       begin ax = cx - y; ay = cy + x; end
            6:       begin ax = cx - y; ay = cy - x; end
            default: begin ax = cx + x; ay = cy + y; end
         endcase
         pt.px     = PT_W'(ax);
         pt.py     = PT_W'(ay);
         pt.last   = (k == POINTS_PER_STEP - 1);
         pt.done   = done;
         pt.status = STATUS_POINT;
         expected_points.push_back(pt);
      end
   endtask

   // Step the arc for one accepted request and queue what it must emit
   task automatic predict_points(input logic kind, input logic [REQ_DATA_W-1:0] data);
      int               nx, ny, d;
      circle_point_type pt;
      if (kind == REQ_START) begin
         ctr_x   = data[COORD_W-1:0];
         ctr_y   = data[2*COORD_W-1:COORD_W];
         pos_x   = '0;
         pos_y   = data[2*COORD_W+RADIUS_W-1:2*COORD_W];
         d       = pos_y;
         dec_val = DEC_W'(1 - d);
         arc_on  = (pos_y != '0);
         push_octants(!arc_on);
      end else if (!arc_on) begin
         pt.px     = '0;
         pt.py     = '0;
         pt.last   = 1'b1;
         pt.done   = 1'b0;
         pt.status = STATUS_IDLE;
         expected_points.push_back(pt);
      end else begin
         nx = pos_x;
         ny = pos_y;
         d  = dec_val;
         nx = nx + 1;
         if (d < 0) begin
            d = d + 2 * nx + 1;
         end else begin
            ny = ny - 1;
            d  = d + 2 * nx + 1 - 2 * ny;
         end
         dec_val = DEC_W'(d);
         pos_x   = RADIUS_W'(nx);
         pos_y   = RADIUS_W'(ny);
         if (pos_x >= pos_y) begin
            arc_on = 1'b0;
            push_octants(1'b1);
         end else begin
            push_octants(1'b0);
         end
      end
   endtask

   task automatic compare_field(input string what, input int want, input int got);
      if (want != got) begin
         fail_total++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Points first, then requests: a point can never come from a request
   // accepted at the same edge
   always @(posedge clock) begin
      circle_point_type       want;
      logic signed [PT_W-1:0] got_x;
      logic signed [PT_W-1:0] got_y;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_x = rsp_tdata[PT_W-1:0];
            got_y = rsp_tdata[2*PT_W-1:PT_W];
            if (expected_points.size() == 0) begin
               fail_total++;
               $display("%0t: point with none owed, expected nothing, actual (%0d, %0d)",
                        $time, got_x, got_y);
            end else begin
               want = expected_points.pop_front();
               compare_field("point_x", want.px, got_x);
               compare_field("point_y", want.py, got_y);
               compare_field("last_in_run", want.last, rsp_tlast);
               compare_field("arc_done", want.done, rsp_tuser[0]);
               compare_field("status", want.status, rsp_tuser[1]);
            end
         end
         if (req_tvalid && req_tready)
            predict_points(req_tuser, req_tdata);
      end
      mismatch_count <= fail_total;
      open_points    <= expected_points.size();
   end

endmodule

/* verif/midpoint_circle_octant_generator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle octant generator test
// Drives start and advance requests into the generator: directed corner
// cases, a long output hold-off that backs up the job queue, then random
// circles mostly stepped to completion. A point monitor predicts and checks
// every point; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module midpoint_circle_octant_generator_test;
   import mcog_pkg::*;

   localparam int RADIUS_W     = RADIUS_BITS_DEF;
   localparam int COORD_W      = COORD_BITS_DEF;
   localparam int REQ_DATA_W   = ((2 * COORD_W + RADIUS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((2 * (COORD_W + 1) + 7) / 8) * 8;
   localparam int FIELD_BITS   = 2 * COORD_W + RADIUS_W;
   localparam int RANDOM_ITEMS = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 64;
   localparam int CYCLE_LIMIT  = 500000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // center_x, center_y, radius
   logic                  req_tuser  = 1'b0;  // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // point_x, point_y
   logic                  rsp_tlast;          // last_in_run
   logic [1:0]            rsp_tuser;          // arc_done, status

   int          mismatch_count;
   int          open_points;
   int          items_sent   = 0;
   int          burst_left   = 0;
   int unsigned cycle_count  = 0;
   logic        hold_request = 1'b0;

   // Receiver pacing state
   int   stall_left = 0;
   int   run_left   = 0;
   int   hold_left  = 0;
   logic hold_taken = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   midpoint_circle_octant_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   circle_point_monitor #(
      .REQ_DATA_W (REQ_DATA_W),
      .RSP_DATA_W (RSP_DATA_W)
   ) point_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .open_points    (open_points)
   );

   // Point receiver: short and long stalls, runs of full rate, one long hold
   always @(posedge clock) begin
      int pick;
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (run_left != 0) begin
         run_left--;
         rsp_tready <= 1'b1;
      end else begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            stall_left = $urandom_range(20, 60);
         else if (pick < 8)
            stall_left = $urandom_range(0, 2);
         else
            run_left = $urandom_range(0, 30);
         rsp_tready <= (pick >= 8);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[midpoint_circle_octant_generator] ERROR");
         $finish;
      end
   end

   // Offer one request and wait until it is taken; eager skips the idle gap.
   // Now and then the padding bits above the fields carry junk.
   task automatic offer_item(input logic kind, input int cx, input int cy, input int rad,
                             input bit eager);
      int                    gap;
      int                    pick;
      logic [REQ_DATA_W-1:0] data;
      gap = 0;
      if (!eager) begin
         if (burst_left != 0) begin
            burst_left--;
         end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               gap = $urandom_range(15, 50);
            else if (pick < 8)
               gap = $urandom_range(1, 3);
            else if (pick < 10)
               burst_left = $urandom_range(5, 20);
         end
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      data = '0;
      if ($urandom_range(0, 7) == 0)
         data = REQ_DATA_W'({$urandom, $urandom});
      data[COORD_W-1:0]                    = cx[COORD_W-1:0];
      data[2*COORD_W-1:COORD_W]            = cy[COORD_W-1:0];
      data[FIELD_BITS-1:2*COORD_W]         = rad[RADIUS_W-1:0];
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   initial begin
      int rad;
      int steps;
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle advance, zero radius, radius one at the low corner
      offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      offer_item(REQ_START, 0, 0, 0, 0);
      offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      offer_item(REQ_START, -2048, -2048, 1, 0);
      offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      // Largest radius at the high corner, then abandoned by a new start
      offer_item(REQ_START, 2047, 2047, 1023, 0);
      repeat (3) offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      offer_item(REQ_START, -2048, 2047, 5, 0);
      repeat (5) offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      offer_item(REQ_START, 2047, -2048, 1023, 0);
      repeat (2) offer_item(REQ_ADVANCE, 0, 0, 0, 0);
      offer_item(REQ_START, 'h555, 'haaa, 2, 0);
      repeat (3) offer_item(REQ_ADVANCE, 0, 0, 0, 0);

      // Back pressure: receiver holds off while requests keep coming
      hold_request <= 1'b1;
      offer_item(REQ_START, $urandom_range(0, 4095), $urandom_range(0, 4095), 1023, 1);
      repeat (14) offer_item(REQ_ADVANCE, 0, 0, 0, 1);

      // Random circles, mostly stepped past their end, some cut short
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            offer_item(REQ_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 1023), 0);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: rad = $urandom_range(0, 16);
               7, 8:                rad = $urandom_range(17, 120);
               default:             rad = $urandom_range(121, 1023);
            endcase
            offer_item(REQ_START, $urandom_range(0, 4095), $urandom_range(0, 4095), rad, 0);
            if ($urandom_range(0, 4) == 0)
               steps = $urandom_range(0, 3);
            else
               steps = (rad * 3) / 4 + 2;
            if (steps > 14)
               steps = 14;
            repeat (steps)
               offer_item(REQ_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 1023), 0);
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the pipeline to settle
      @(posedge clock);
      while (open_points != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && open_points == 0)
         $display("[midpoint_circle_octant_generator] OK");
      else
         $display("[midpoint_circle_octant_generator] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mcog_pkg.sv
rtl/mcog_front.sv
rtl/mcog_queue.sv
rtl/mcog_back.sv
rtl/midpoint_circle_octant_generator.sv
rtl/mcog_checker.sv
verif/circle_point_monitor.sv
verif/midpoint_circle_octant_generator_test.sv
